/* hw/rtl/sha512_pkg.sv */
// ----------------------------------------------------------------------------
// sha512_pkg
// types, round constants and initial value for the sha-512 engine
// ----------------------------------------------------------------------------
`default_nettype none
package sha512_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_of_message;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // round unit controls
    typedef struct packed {
        logic load;
        logic step;
    } t_rnd_ctl;

    localparam int unsigned NumRounds = 80;

    function automatic logic [63:0] f_iv(input logic [2:0] i);
        logic [63:0] r;
        case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    localparam logic [63:0] RoundConst [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage
`default_nettype wire

/* hw/rtl/sha512_sched.sv */
// ----------------------------------------------------------------------------
// sha512_sched
// sixteen-word message schedule window, one new word per round
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_sched
    import sha512_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_wr,
    input  wire logic [3:0]  i_wr_pos,
    input  wire logic [63:0] i_wr_data,
    input  wire logic        i_step,
    output logic      [63:0] o_w
);

    logic [63:0] r_win [16];
    logic [63:0] s0, s1, nw;

    assign o_w = r_win[0];
    assign s1 = {r_win[14][18:0], r_win[14][63:19]} ^ {r_win[14][60:0], r_win[14][63:61]}
              ^ (r_win[14] >> 6);
    assign s0 = {r_win[1][0], r_win[1][63:1]} ^ {r_win[1][7:0], r_win[1][63:8]}
              ^ (r_win[1] >> 7);
    assign nw = s1 + r_win[9] + s0 + r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int k = 0; k < 15; k++) r_win[k] <= r_win[k+1];
            r_win[15] <= nw;
        end else if (i_wr) begin
            r_win[i_wr_pos] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sha512_round.sv */
// ----------------------------------------------------------------------------
// sha512_round
// working variables and the shared compression round unit
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_round
    import sha512_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_rnd_ctl    i_ctl,
    input  wire logic [63:0] i_chain [8],
    input  wire logic [63:0] i_w,
    input  wire logic [63:0] i_k,
    output logic      [63:0] o_v [8]
);

    logic [63:0] r_v [8];
    logic [63:0] ch, maj, b0, b1, t1, t2;

    assign o_v = r_v;
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign b1  = {r_v[4][13:0], r_v[4][63:14]} ^ {r_v[4][17:0], r_v[4][63:18]}
               ^ {r_v[4][40:0], r_v[4][63:41]};
    assign b0  = {r_v[0][27:0], r_v[0][63:28]} ^ {r_v[0][33:0], r_v[0][63:34]}
               ^ {r_v[0][38:0], r_v[0][63:39]};
    assign t1  = r_v[7] + b1 + ch + i_k + i_w;
    assign t2  = b0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_chain;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sha512_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha512_hash_engine
// sha-512 digest of a word stream, one compression round per cycle
// ----------------------------------------------------------------------------
// input channel: one 64-bit big-endian message word per handshake, with a
// valid byte count and a last mark. a word that does not complete a block is
// taken without a stall. the sixteenth word of a block starts the 80 rounds and
// then the fold, during which o_ready is low and no further word is taken.
// a last word appends padding and length, one word per cycle, running one or
// two compressions, then presents eight digest words on the output channel,
// index 0 first. a stalled receiver holds the current digest word; no input
// is taken until all eight are delivered. afterwards the chaining value, byte
// count and word position are back at their initial values, as after reset.
// reset is synchronous and active low; it clears control state and loads the
// initial hash value.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_word      o_data
);

    t_state       r_state, n_state;
    logic [63:0]  r_chain [8];
    logic [3:0]   r_pos;
    logic [127:0] r_cnt;
    logic [6:0]   r_rnd;
    logic [2:0]   r_oidx;
    logic         r_fin;      // padding in progress
    logic         r_lenok;    // length words go in this block
    logic [63:0]  r_pend;     // padding word still to store (first after full last word)
    logic         r_havep;
    logic [1:0]   r_lenph;

    logic        wr;
    logic [63:0] wr_data;
    logic [63:0] w, v [8];
    t_rnd_ctl    ctl;

    sha512_sched u_sched (
        .i_clk(i_clk), .i_wr(wr), .i_wr_pos(r_pos), .i_wr_data(wr_data),
        .i_step(ctl.step), .o_w(w)
    );

    sha512_round u_round (
        .i_clk(i_clk), .i_ctl(ctl), .i_chain(r_chain), .i_w(w),
        .i_k(RoundConst[r_rnd]), .o_v(v)
    );

    logic [3:0]   nv;
    logic [63:0]  mask, padw;
    logic [127:0] cnt_add;
    always_comb begin
        nv = (i_data.valid_bytes > 4'd8) ? 4'd8 : i_data.valid_bytes;
        mask = (nv == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nv[3:0], 3'b000});
        padw = (i_data.data_word & mask) | (64'h80 << (7'd56 - {nv[3:0], 3'b000}));
        cnt_add = r_cnt + {124'd0, (i_data.last_of_message ? nv : 4'd8)};
    end

    always_comb begin
        n_state = r_state;
        wr = 1'b0;
        wr_data = i_data.data_word;
        ctl = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    wr = 1'b1;
                    if (i_data.last_of_message && nv != 4'd8) wr_data = padw;
                    if (r_pos == 4'd15) begin
                        ctl.load = 1'b1;
                        n_state = ST_ROUND;
                    end else if (i_data.last_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                wr = 1'b1;
                if (r_havep) wr_data = r_pend;
                else if (r_lenok && r_pos == 4'd14) wr_data = {r_cnt[124:64], r_cnt[63:61]};
                else if (r_lenok && r_pos == 4'd15) wr_data = {r_cnt[60:0], 3'b000};
                else wr_data = 64'd0;
                if (r_pos == 4'd15) begin
                    ctl.load = 1'b1;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctl.step = 1'b1;
                if (r_rnd == 7'(NumRounds - 1)) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                if (!r_fin) n_state = ST_IDLE;
                else if (r_lenph == 2'd1 && r_lenok) n_state = ST_EMIT;
                else n_state = ST_PAD;
            end
            ST_EMIT: begin
                if (i_ready && r_oidx == 3'd7) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = (r_state == ST_EMIT);
    assign o_data.digest_word  = r_chain[r_oidx];
    assign o_data.digest_index = r_oidx;
    assign o_data.digest_last  = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int k = 0; k < 8; k++) r_chain[k] <= f_iv(3'(k));
            r_pos <= '0; r_cnt <= '0; r_rnd <= '0; r_oidx <= '0;
            r_fin <= 1'b0; r_lenok <= 1'b0; r_havep <= 1'b0; r_lenph <= '0;
            r_pend <= '0;
        end else begin
            r_state <= n_state;
            if (wr) r_pos <= r_pos + 4'd1;
            if (r_state == ST_IDLE && i_valid) begin
                r_cnt <= cnt_add;
                if (i_data.last_of_message) begin
                    r_fin <= 1'b1;
                    r_havep <= (nv == 4'd8);
                    r_pend <= 64'h8000000000000000;
                    // length fits if pad word lands at or before slot 13
                    r_lenok <= (nv == 4'd8) ? (r_pos <= 4'd12) : (r_pos <= 4'd13);
                    r_lenph <= ((nv == 4'd8) ? (r_pos <= 4'd12) : (r_pos <= 4'd13))
                               ? 2'd1 : 2'd0;
                end
            end
            if (r_state == ST_PAD) begin
                r_havep <= 1'b0;
                if (r_havep && r_pos <= 4'd13) begin
                    r_lenok <= 1'b1;
                    if (r_lenph == 2'd0) r_lenph <= 2'd1;
                end
            end
            if (r_state == ST_ROUND) r_rnd <= (n_state == ST_FOLD) ? 7'd0 : r_rnd + 7'd1;
            if (r_state == ST_FOLD) begin
                for (int k = 0; k < 8; k++) r_chain[k] <= r_chain[k] + v[k];
                if (r_fin) begin
                    if (r_lenph == 2'd1 && r_lenok) r_lenph <= 2'd2;
                    else if (!r_havep) r_lenok <= 1'b1;
                    if (r_lenph == 2'd0 && !r_havep) r_lenph <= 2'd1;
                end
            end
            if (r_state == ST_EMIT && i_ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    for (int k = 0; k < 8; k++) r_chain[k] <= f_iv(3'(k));
                    r_cnt <= '0; r_pos <= '0; r_fin <= 1'b0;
                    r_lenok <= 1'b0; r_lenph <= '0; r_havep <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire
